>>> hw/rtl/linear_probe_hash_table_core_assert.svh
// assertion macros used by the hash table controller
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// antecedent in this cycle implies consequent in the same cycle
`define LPHT_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define LPHT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/lpht_pkg.sv
// types, codes and fixed widths for the linear probe hash table
package lpht_pkg;

	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int CFG_W      = 11;
	localparam int CFG_RESET  = 1024;
	localparam int DIV_STEP   = 4;
	localparam int DIV_CYCLES = KEY_W / DIV_STEP;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_FOUND    = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_PRESENT  = 3'd3,
		ST_ZEROVAL  = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] value_out;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    home;
		logic    advance;
		logic    clr_step;
		logic    wr_insert;
		logic    res_load;
		logic    res_found;
		status_t res_status;
		logic    out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic empty;
		logic match;
		logic last_probe;
		logic clr_last;
		logic kind_ins;
		logic zero_val;
	} sts_t;

endpackage

>>> hw/rtl/lpht_ram.sv
// generic single write port, single read port ram with registered read
module lpht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/lpht_mod.sv
// iterative remainder unit, key modulo slot count, several bits per cycle
module lpht_mod #(
	parameter int AW = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lpht_pkg::KEY_W-1:0] dividend,
	input  logic [AW:0]              divisor,
	output logic [AW-1:0]            rem,
	output logic                     done
);
	import lpht_pkg::*;

	logic [KEY_W-1:0]     dvd_q;
	logic [AW-1:0]        rem_q;
	logic [AW-1:0]        rem_next;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// restoring steps, msb of the key first
	always_comb begin
		logic [AW:0]   t;
		logic [AW-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			t = {r, dvd_q[KEY_W-1-i]};
			if (t >= divisor) begin
				t = t - divisor;
			end
			r = t[AW-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << DIV_STEP;
			rem_q <= rem_next;
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

>>> hw/rtl/lpht_datapath.sv
// datapath: request registers, slot count, probe index, slot store, result registers
module lpht_datapath #(
	parameter int MAX_SLOTS = 1024,
	parameter int AW        = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lpht_pkg::req_t           in_data,
	input  logic                     cfg_we,
	input  logic [lpht_pkg::CFG_W-1:0] cfg_wdata,
	input  lpht_pkg::cmd_t           cmd,
	output lpht_pkg::sts_t           sts,
	output lpht_pkg::rsp_t           out_data
);
	import lpht_pkg::*;

	localparam int NW      = AW + 1;
	localparam int N_RESET = (CFG_RESET > MAX_SLOTS) ? MAX_SLOTS : CFG_RESET;

	logic [NW-1:0]          n_q;
	logic [31:0]            size_ext;
	logic [31:0]            n_clamped;
	logic [NW-1:0]          nm1;
	logic                   kind_q;
	logic [KEY_W-1:0]       key_q;
	logic [VAL_W-1:0]       val_q;
	logic [AW-1:0]          idx_q;
	logic [AW-1:0]          cnt_q;
	logic [NW-1:0]          idx_inc;
	logic [AW-1:0]          home_idx;
	logic                   div_done;
	logic                   ram_we;
	logic [KEY_W+VAL_W-1:0] ram_wdata;
	logic [KEY_W+VAL_W-1:0] ram_rdata;
	logic [KEY_W-1:0]       rd_key;
	logic [VAL_W-1:0]       rd_val;
	status_t                res_status_q;
	logic [VAL_W-1:0]       res_value_q;
	rsp_t                   out_q;

	// zero counts as one slot, anything above the store counts as the store
	assign size_ext  = 32'(cfg_wdata);
	assign n_clamped = (size_ext == 32'd0) ? 32'd1 :
		((size_ext > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS) : size_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= NW'(N_RESET);
		end else if (cfg_we) begin
			n_q <= n_clamped[NW-1:0];
		end
	end

	// probe index doubles as the clearing sweep address after reset
	assign idx_inc = {1'b0, idx_q} + NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.clr_step) begin
			idx_q <= idx_inc[AW-1:0];
		end else if (cmd.home) begin
			idx_q <= home_idx;
		end else if (cmd.advance) begin
			idx_q <= (idx_inc >= n_q) ? '0 : idx_inc[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_data.kind;
			key_q  <= in_data.key;
			val_q  <= in_data.value_in;
		end
		if (cmd.home) begin
			cnt_q <= '0;
		end else if (cmd.advance) begin
			cnt_q <= cnt_q + AW'(1);
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_found ? rd_val : '0;
		end
		if (cmd.out_load) begin
			out_q.status    <= res_status_q;
			out_q.value_out <= res_value_q;
		end
	end

	lpht_mod #(
		.AW(AW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.capture),
		.dividend(in_data.key),
		.divisor (n_q),
		.rem     (home_idx),
		.done    (div_done)
	);

	assign ram_we    = cmd.clr_step | cmd.wr_insert;
	assign ram_wdata = cmd.clr_step ? '0 : {key_q, val_q};

	lpht_ram #(
		.WIDTH(KEY_W + VAL_W),
		.DEPTH(MAX_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign rd_key = ram_rdata[KEY_W+VAL_W-1:VAL_W];
	assign rd_val = ram_rdata[VAL_W-1:0];
	assign nm1    = n_q - NW'(1);

	assign sts.div_done   = div_done;
	assign sts.empty      = (rd_val == '0);
	assign sts.match      = (rd_key == key_q);
	assign sts.last_probe = (cnt_q == nm1[AW-1:0]);
	assign sts.clr_last   = (idx_q == AW'(MAX_SLOTS - 1));
	assign sts.kind_ins   = (kind_q == KIND_INSERT);
	assign sts.zero_val   = (val_q == '0);

	assign out_data = out_q;

endmodule

>>> hw/rtl/lpht_ctrl.sv
// controller: clearing sweep, hashing, probe sequencing and result handoff
`include "linear_probe_hash_table_core_assert.svh"

module lpht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  lpht_pkg::sts_t sts,
	output lpht_pkg::cmd_t cmd
);
	import lpht_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.res_status = ST_NOTFOUND;
		state_next = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_next = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.div_done) begin
					cmd.home   = 1'b1;
					state_next = S_READ;
				end
			end
			S_READ: begin
				state_next = S_CHECK;
			end
			S_CHECK: begin
				if (sts.empty) begin
					cmd.res_load = 1'b1;
					state_next   = S_DONE;
					if (!sts.kind_ins) begin
						cmd.res_status = ST_NOTFOUND;
					end else if (sts.zero_val) begin
						cmd.res_status = ST_ZEROVAL;
					end else begin
						cmd.wr_insert  = 1'b1;
						cmd.res_status = ST_INSERTED;
					end
				end else if (sts.match) begin
					cmd.res_load   = 1'b1;
					cmd.res_found  = !sts.kind_ins;
					cmd.res_status = sts.kind_ins ? ST_PRESENT : ST_FOUND;
					state_next     = S_DONE;
				end else if (sts.last_probe) begin
					// every slot in use visited without a hole or a match
					cmd.res_load = 1'b1;
					state_next   = S_DONE;
					if (!sts.kind_ins) begin
						cmd.res_status = ST_NOTFOUND;
					end else if (sts.zero_val) begin
						cmd.res_status = ST_ZEROVAL;
					end else begin
						cmd.res_status = ST_FULL;
					end
				end else begin
					cmd.advance = 1'b1;
					state_next  = S_READ;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`LPHT_ASSERT_SAME(a_insert_only_into_hole, clk, arst_n, cmd.wr_insert, sts.empty && sts.kind_ins && !sts.zero_val, "insert write without a hole or with a zero value")
	`LPHT_ASSERT_SAME(a_no_result_while_clearing, clk, arst_n, state_q == S_CLEAR, !out_valid_q, "result offered during the clearing sweep")
	`LPHT_ASSERT_NEXT(a_divider_restarts, clk, arst_n, in_valid && in_ready, !sts.div_done, "stale home slot visible after a new transaction")
	`LPHT_ASSERT_NEXT(a_probe_bounded, clk, arst_n, state_q == S_CHECK && sts.last_probe, state_q == S_DONE, "probe continued past the last slot in use")

endmodule

>>> hw/rtl/linear_probe_hash_table_core.sv
// top level of the linear probe hash table: controller, datapath and slot store
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (kind, key, value_in)
//   out      output     out_valid / out_ready  out_data  (status, value_out)
//   cfg      input      cfg_we                 cfg_wdata (table_size)
//
// after reset a sweep clears every slot of the store, one slot a cycle;
// in_ready stays low during that sweep
// a transaction runs the key modulo unit once, then makes p probes (1 up to
// table_size) before out_valid; each probe is a registered ram read and a compare
// a new request is taken while a result waits on out_ready; a finished result
// holds in the datapath result registers until the output register frees
module linear_probe_hash_table_core #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  lpht_pkg::req_t             in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output lpht_pkg::rsp_t             out_data,
	input  logic                       cfg_we,
	input  logic [lpht_pkg::CFG_W-1:0] cfg_wdata
);
	import lpht_pkg::*;

	localparam int AW = $clog2(MAX_SLOTS);

	cmd_t cmd;
	sts_t sts;

	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpht_datapath #(
		.MAX_SLOTS(MAX_SLOTS),
		.AW       (AW)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
